>>> design/ows_pkg.sv
package ows_pkg;

	localparam int ROM_BITS = 64;
	localparam int BP_W     = $clog2(ROM_BITS + 1);

	localparam logic [7:0] SLOT_RESET = 8'hf0;
	localparam logic [7:0] SLOT_ONE   = 8'hff;
	localparam logic [7:0] SLOT_ZERO  = 8'h00;
	localparam logic [7:0] SEARCH_CMD = 8'hf0;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_ECHO  = 1'b1;

	localparam int IN_W  = 16;
	localparam int OUT_W = 88;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RESET,
		PH_CMD,
		PH_READ1,
		PH_READ2,
		PH_WRITE
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DONE,
		ST_SHORT,
		ST_DATA_ERR
	} status_t;

	typedef struct packed {
		phase_t                phase;
		logic [2:0]            cmd_cnt;
		logic [BP_W-1:0]       bit_pos;
		logic [7:0]            search_disc;
		logic [6:0]            found_disc;
		logic                  first_bit;
		logic [ROM_BITS-1:0]   rom;
	} state_t;

	typedef struct packed {
		logic                  tx_valid;
		logic [7:0]            tx_byte;
		logic                  slow_baud;
		logic                  pass_done;
		status_t               status;
		logic [6:0]            next_disc;
		logic [ROM_BITS-1:0]   rom;
	} result_t;

endpackage

>>> design/onewire_rom_search_uart_master.sv
// channel | dir | tdata (low bit up)                                      | side
// s       | in  | start_diff[7:0], echo_byte[15:8]                        | tuser = mode
// m       | out | tx_valid, tx_byte, slow_baud, status, next_discrepancy, | tlast = pass_done
//         |     | rom_code, zero pad to 88 bits                           |
// One item per cycle while s_tready is high; its registered result appears the next cycle.
// s_tready stays high while the output register is empty or being taken.
// An echo item while idle updates nothing and gives no result.
// arst_n clears the search state and the output valid flag.
module onewire_rom_search_uart_master (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ows_pkg::IN_W-1:0]  s_tdata,   // start_diff, echo_byte
	input  logic                      s_tuser,   // mode
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ows_pkg::OUT_W-1:0] m_tdata,   // tx_valid, tx_byte, slow_baud, status,
	                                             // next_discrepancy, rom_code
	output logic                      m_tlast    // pass_done
);

	ows_pkg::state_t  state_q;
	ows_pkg::state_t  state_nxt;
	ows_pkg::result_t res;
	ows_pkg::result_t out_q;
	logic             res_valid;
	logic             out_valid_q;
	logic             s_acc;

	assign s_tready = !out_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	ows_step u_step (
		.cur        (state_q),
		.mode       (s_tuser),
		.start_diff (s_tdata[7:0]),
		.echo_byte  (s_tdata[15:8]),
		.nxt        (state_nxt),
		.res        (res),
		.res_valid  (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= ows_pkg::PH_IDLE;
			state_q.cmd_cnt     <= 3'd0;
			state_q.bit_pos     <= '0;
			state_q.search_disc <= 8'd0;
			state_q.found_disc  <= 7'd0;
			state_q.first_bit   <= 1'b0;
			state_q.rom         <= '0;
			out_valid_q         <= 1'b0;
		end else begin
			if (s_acc)
				state_q <= state_nxt;
			if (s_acc && res_valid)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.pass_done;
	assign m_tdata  = {5'd0, 64'(out_q.rom), out_q.next_disc, out_q.status,
		out_q.slow_baud, out_q.tx_byte, out_q.tx_valid};

	a_start_reset_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (s_tuser == ows_pkg::MODE_START)) |=>
		(m_tvalid && m_tdata[9] && (m_tdata[8:1] == ows_pkg::SLOT_RESET)))
		else $error("start item did not produce a slow reset slot");

	a_done_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !m_tdata[0])
		else $error("pass end carries a slot to send");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[11:10] != ows_pkg::ST_RUN)))
		else $error("status and pass end disagree");

	a_tx_or_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || m_tlast))
		else $error("result with neither slot nor pass end");

	a_idle_echo_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (s_tuser == ows_pkg::MODE_ECHO) && (state_q.phase == ows_pkg::PH_IDLE)
		&& !m_tvalid) |=> !m_tvalid)
		else $error("echo while idle produced a result");

endmodule

>>> design/ows_step.sv
module ows_step (
	input  ows_pkg::state_t  cur,
	input  logic             mode,
	input  logic [7:0]       start_diff,
	input  logic [7:0]       echo_byte,
	output ows_pkg::state_t  nxt,
	output ows_pkg::result_t res,
	output logic             res_valid
);

	logic                     echo_one;
	logic                     reset_fail;
	logic [ows_pkg::BP_W-1:0] pos;
	logic [ows_pkg::BP_W-1:0] bp_inc;
	logic                     bp_last;
	logic [2:0]               cmd_inc;
	logic                     disc_take;
	logic                     dir;

	assign echo_one   = (echo_byte == ows_pkg::SLOT_ONE);
	assign reset_fail = (echo_byte == ows_pkg::SLOT_ZERO) || (echo_byte == ows_pkg::SLOT_RESET);
	assign pos        = ows_pkg::BP_W'(ows_pkg::ROM_BITS) - cur.bit_pos;
	assign bp_inc     = cur.bit_pos + ows_pkg::BP_W'(1);
	assign bp_last    = (bp_inc >= ows_pkg::BP_W'(ows_pkg::ROM_BITS));
	assign cmd_inc    = cur.cmd_cnt + 3'd1;
	// both reads zero: devices disagree here, pick direction from history
	assign disc_take  = !cur.first_bit && !echo_one &&
		((cur.search_disc > 8'(pos)) || (cur.rom[0] && (cur.search_disc != 8'(pos))));
	assign dir        = cur.first_bit || disc_take;

	always_comb begin
		nxt = cur;
		if (mode == ows_pkg::MODE_START) begin
			nxt.search_disc = start_diff;
			nxt.found_disc  = 7'd0;
			nxt.bit_pos     = '0;
			nxt.cmd_cnt     = 3'd0;
			nxt.first_bit   = 1'b0;
			nxt.phase       = ows_pkg::PH_RESET;
		end else begin
			case (cur.phase)
				ows_pkg::PH_RESET: begin
					if (reset_fail) begin
						nxt.phase      = ows_pkg::PH_IDLE;
						nxt.found_disc = 7'd0;
					end else begin
						nxt.cmd_cnt = 3'd0;
						nxt.phase   = ows_pkg::PH_CMD;
					end
				end
				ows_pkg::PH_CMD: begin
					if (cur.cmd_cnt == 3'd7) begin
						nxt.cmd_cnt = 3'd0;
						nxt.phase   = ows_pkg::PH_READ1;
					end else begin
						nxt.cmd_cnt = cmd_inc;
					end
				end
				ows_pkg::PH_READ1: begin
					nxt.first_bit = echo_one;
					nxt.phase     = ows_pkg::PH_READ2;
				end
				ows_pkg::PH_READ2: begin
					if (cur.first_bit && echo_one) begin
						nxt.phase = ows_pkg::PH_IDLE;
					end else begin
						if (disc_take)
							nxt.found_disc = 7'(pos);
						nxt.rom   = {dir, cur.rom[ows_pkg::ROM_BITS-1:1]};
						nxt.phase = ows_pkg::PH_WRITE;
					end
				end
				ows_pkg::PH_WRITE: begin
					nxt.bit_pos = bp_inc;
					nxt.phase   = bp_last ? ows_pkg::PH_IDLE : ows_pkg::PH_READ1;
				end
				default: begin
					nxt.phase = ows_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res_valid     = 1'b1;
		res.tx_valid  = 1'b1;
		res.tx_byte   = ows_pkg::SLOT_ONE;
		res.slow_baud = 1'b0;
		res.pass_done = 1'b0;
		res.status    = ows_pkg::ST_RUN;
		res.next_disc = nxt.found_disc;
		res.rom       = nxt.rom;
		if (mode == ows_pkg::MODE_START) begin
			res.tx_byte   = ows_pkg::SLOT_RESET;
			res.slow_baud = 1'b1;
		end else begin
			case (cur.phase)
				ows_pkg::PH_RESET: begin
					if (reset_fail) begin
						res.tx_valid  = 1'b0;
						res.tx_byte   = 8'h00;
						res.pass_done = 1'b1;
						res.status    = ows_pkg::ST_SHORT;
					end else begin
						res.tx_byte = ows_pkg::SEARCH_CMD[0] ? ows_pkg::SLOT_ONE
							: ows_pkg::SLOT_ZERO;
					end
				end
				ows_pkg::PH_CMD: begin
					if (cur.cmd_cnt != 3'd7)
						res.tx_byte = ows_pkg::SEARCH_CMD[cmd_inc] ? ows_pkg::SLOT_ONE
							: ows_pkg::SLOT_ZERO;
				end
				ows_pkg::PH_READ1: begin
					res.tx_byte = ows_pkg::SLOT_ONE;
				end
				ows_pkg::PH_READ2: begin
					if (cur.first_bit && echo_one) begin
						res.tx_valid  = 1'b0;
						res.tx_byte   = 8'h00;
						res.pass_done = 1'b1;
						res.status    = ows_pkg::ST_DATA_ERR;
					end else begin
						res.tx_byte = dir ? ows_pkg::SLOT_ONE : ows_pkg::SLOT_ZERO;
					end
				end
				ows_pkg::PH_WRITE: begin
					if (bp_last) begin
						res.tx_valid  = 1'b0;
						res.tx_byte   = 8'h00;
						res.pass_done = 1'b1;
						res.status    = ows_pkg::ST_DONE;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

endmodule
